FILE: sv/assert_macros.svh
// assertion helpers for the tokenizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

FILE: sv/stt_pkg.sv
package stt_pkg;
	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	localparam logic [4:0] M_IDLE = 5'd0;
	localparam logic [4:0] M_EQ = 5'd1;
	localparam logic [4:0] M_PIPE = 5'd2;
	localparam logic [4:0] M_AMP = 5'd3;
	localparam logic [4:0] M_BANG = 5'd4;
	localparam logic [4:0] M_LT = 5'd5;
	localparam logic [4:0] M_GT = 5'd6;
	localparam logic [4:0] M_PLUS = 5'd7;
	localparam logic [4:0] M_ZERO = 5'd8;
	localparam logic [4:0] M_INT = 5'd9;
	localparam logic [4:0] M_DOT = 5'd10;
	localparam logic [4:0] M_FRAC = 5'd11;
	localparam logic [4:0] M_EXP = 5'd12;
	localparam logic [4:0] M_EXPSIGN = 5'd13;
	localparam logic [4:0] M_EXPDIG = 5'd14;
	localparam logic [4:0] M_STR = 5'd15;
	localparam logic [4:0] M_NAME = 5'd16;

	localparam logic [5:0] K_EOF = 6'd0;
	localparam logic [5:0] K_EQGT = 6'd9;
	localparam logic [5:0] K_EQEQ = 6'd10;
	localparam logic [5:0] K_EQ = 6'd11;
	localparam logic [5:0] K_PIPEGT = 6'd12;
	localparam logic [5:0] K_PIPEPIPE = 6'd13;
	localparam logic [5:0] K_AMPAMP = 6'd14;
	localparam logic [5:0] K_BANGEQ = 6'd15;
	localparam logic [5:0] K_BANG = 6'd16;
	localparam logic [5:0] K_LTEQ = 6'd17;
	localparam logic [5:0] K_LT = 6'd18;
	localparam logic [5:0] K_GTEQ = 6'd19;
	localparam logic [5:0] K_GT = 6'd20;
	localparam logic [5:0] K_PLUSPLUS = 6'd21;
	localparam logic [5:0] K_PLUS = 6'd22;
	localparam logic [5:0] K_MINUS = 6'd23;
	localparam logic [5:0] K_STAR = 6'd24;
	localparam logic [5:0] K_SLASH = 6'd25;
	localparam logic [5:0] K_PERCENT = 6'd26;
	localparam logic [5:0] K_NUMBER = 6'd27;
	localparam logic [5:0] K_STRING = 6'd28;
	localparam logic [5:0] K_FALSE = 6'd29;
	localparam logic [5:0] K_NAME = 6'd33;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_UNEXP = 2'd1;
	localparam logic [1:0] E_UNTERM = 2'd2;

	typedef struct packed {
		logic [5:0] kind;
		logic [1:0] err;
		logic [7:0] bad;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] off;
		logic [15:0] len;
	} tok_t;

	// scanner state held between bytes
	typedef struct packed {
		logic [4:0] mode;
		logic [POS_BITS-1:0] cur_line;
		logic [POS_BITS-1:0] cur_col;
		logic [POS_BITS-1:0] pos;
		logic [POS_BITS-1:0] st_line;
		logic [POS_BITS-1:0] st_col;
		logic [POS_BITS-1:0] st_pos;
		logic [POS_BITS-1:0] plen;
		logic [3:0] kw;
		logic [7:0] first;
		logic stopped;
	} scan_t;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] a,
			input logic [1:0] b);
		logic [POS_BITS:0] s;
		s = {1'b0, a} + {{(POS_BITS-1){1'b0}}, b};
		return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
			input logic [POS_BITS-1:0] b);
		logic [POS_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		logic [39:0] s;
		case (k)
			2'd0: s = "false";
			2'd1: s = {"let", 16'h0};
			2'd2: s = {"nil", 16'h0};
			default: s = {"true", 8'h0};
		endcase
		case (i)
			3'd0: return s[39:32];
			3'd1: return s[31:24];
			3'd2: return s[23:16];
			3'd3: return s[15:8];
			3'd4: return s[7:0];
			default: return 8'h0;
		endcase
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		case (k)
			2'd0: return 3'd5;
			2'd1: return 3'd3;
			2'd2: return 3'd3;
			default: return 3'd4;
		endcase
	endfunction
endpackage

FILE: sv/source_text_tokenizer_unit.sv
// channel   | direction | handshake                  | payload
// byte in   | input     | char_valid / char_ready    | char_byte
// token out | output    | token_valid / token_ready  | token_kind .. last_of_run
//
// bytes are scanned in the cycle accepted; one byte per cycle sustained if token_ready
// the scan is one combinational pass of the state update into a two-entry result queue
// a byte giving two tokens queues both, drained one per cycle while token_ready
// a byte is taken whenever the queue has room for two tokens after this cycle's drain
// reset returns to line 1, column 1, offset 0, between tokens
`include "assert_macros.svh"
module source_text_tokenizer_unit (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	output logic char_ready,
	input logic [7:0] char_byte,
	output logic token_valid,
	input logic token_ready,
	output logic [5:0] token_kind,
	output logic [1:0] error_code,
	output logic [7:0] bad_char,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic [15:0] token_offset,
	output logic [15:0] token_length,
	output logic last_of_run
);
	import stt_pkg::*;

	// scanner state and queue of results with their last flags
	scan_t state_q, state_nxt;
	tok_t q0_q, q1_q, r0, r1;
	logic l0_q, l1_q;
	logic [1:0] cnt_q;
	logic [1:0] n;
	logic take, pop;
	logic [1:0] left;

	stt_step u_step (
		.c(char_byte),
		.cur(state_q),
		.nxt(state_nxt),
		.n(n),
		.r0(r0),
		.r1(r1)
	);

	assign pop = token_valid && token_ready;
	// results left after this cycle's drain
	assign left = cnt_q - {1'b0, pop};
	assign char_ready = (left == 2'd0);
	assign take = char_valid && char_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: M_IDLE, cur_line: POS_BITS'(1), cur_col: POS_BITS'(1),
				st_line: POS_BITS'(1), st_col: POS_BITS'(1), default: '0};
			cnt_q <= 2'd0;
		end else begin
			if (take) state_q <= state_nxt;
			cnt_q <= take ? n : left;
		end
	end

	// payload queue, head at q0
	always_ff @(posedge clk) begin
		if (take) begin
			q0_q <= r0;
			l0_q <= (n == 2'd1);
			q1_q <= r1;
			l1_q <= 1'b1;
		end else if (pop) begin
			q0_q <= q1_q;
			l0_q <= l1_q;
		end
	end

	assign token_valid = (cnt_q != 2'd0);
	assign token_kind = q0_q.kind;
	assign error_code = q0_q.err;
	assign bad_char = q0_q.bad;
	assign token_line = q0_q.line;
	assign token_column = q0_q.col;
	assign token_offset = q0_q.off;
	assign token_length = q0_q.len;
	assign last_of_run = l0_q;

	// a stopped scanner never leaves that state
	`CHK_NEXT(a_stop_holds, clk, arst_n, state_q.stopped, state_q.stopped)
	// no byte taken while results wait beyond the one now leaving
	`CHK_IMPL(a_no_overrun, clk, arst_n, take, left == 2'd0)
	// a lone queued result is always the last of its byte
	`CHK_IMPL(a_last_single, clk, arst_n, cnt_q == 2'd1, l0_q)
endmodule

FILE: sv/stt_step.sv
module stt_step (
	input logic [7:0] c,
	input stt_pkg::scan_t cur,
	output stt_pkg::scan_t nxt,
	output logic [1:0] n,
	output stt_pkg::tok_t r0,
	output stt_pkg::tok_t r1
);
	import stt_pkg::*;

	function automatic logic dig(input logic [7:0] x);
		return x >= "0" && x <= "9";
	endfunction
	function automatic logic alp(input logic [7:0] x);
		return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
	endfunction
	function automatic logic wrd(input logic [7:0] x);
		return dig(x) || alp(x) || x == "_";
	endfunction

	always_comb begin
		scan_t s;
		tok_t t;
		logic again;
		logic [7:0] b;
		logic [5:0] kind;
		logic [2:0] pl3;
		s = cur;
		again = 1'b0;
		n = 2'd0;
		r0 = '0;
		r1 = '0;
		t = '0;
		kind = K_NAME;
		b = 8'h0;
		pl3 = 3'd0;
		if (!cur.stopped) begin
			t.line = to16(cur.st_line);
			t.col = to16(cur.st_col);
			t.off = to16(cur.st_pos);
			b = (cur.first < 8'h20 || cur.first > 8'h7e) ? "?" : cur.first;
			case (cur.mode)
				M_EQ, M_PIPE, M_AMP, M_BANG, M_LT, M_GT, M_PLUS: begin
					logic [7:0] sec;
					logic [5:0] k2, k1;
					case (cur.mode)
						M_EQ: begin sec = "="; k2 = K_EQEQ; k1 = K_EQ; end
						M_PIPE: begin sec = "|"; k2 = K_PIPEPIPE; k1 = K_EOF; end
						M_AMP: begin sec = "&"; k2 = K_AMPAMP; k1 = K_EOF; end
						M_BANG: begin sec = "="; k2 = K_BANGEQ; k1 = K_BANG; end
						M_LT: begin sec = "="; k2 = K_LTEQ; k1 = K_LT; end
						M_GT: begin sec = "="; k2 = K_GTEQ; k1 = K_GT; end
						default: begin sec = "+"; k2 = K_PLUSPLUS; k1 = K_PLUS; end
					endcase
					if (c == ">" && cur.mode == M_EQ) begin
						s.mode = M_IDLE; t.kind = K_EQGT; t.len = 16'd2; n = 2'd1;
					end else if (c == ">" && cur.mode == M_PIPE) begin
						s.mode = M_IDLE; t.kind = K_PIPEGT; t.len = 16'd2; n = 2'd1;
					end else if (c == sec) begin
						s.mode = M_IDLE; t.kind = k2; t.len = 16'd2; n = 2'd1;
					end else if (k1 == K_EOF) begin
						s.stopped = 1'b1; t.err = E_UNEXP; t.bad = b; n = 2'd1;
					end else begin
						t.kind = k1; t.len = 16'd1; n = 2'd1; again = 1'b1;
					end
				end
				M_INT, M_ZERO, M_FRAC, M_EXPDIG: begin
					if (dig(c) && cur.mode != M_ZERO) begin
						s.plen = sat_inc(cur.plen, 2'd1);
					end else if (c == "." && (cur.mode == M_INT || cur.mode == M_ZERO)) begin
						s.mode = M_DOT;
					end else if ((c == "e" || c == "E") && cur.mode != M_EXPDIG) begin
						s.mode = M_EXP;
						s.plen = sat_inc(cur.plen, 2'd1);
					end else if (wrd(c)) begin
						s.stopped = 1'b1; t.err = E_UNEXP; t.bad = b; n = 2'd1;
					end else begin
						t.kind = K_NUMBER; t.len = to16(cur.plen); n = 2'd1; again = 1'b1;
					end
				end
				M_DOT: begin
					if (dig(c)) begin
						s.mode = M_FRAC;
						s.plen = sat_inc(cur.plen, 2'd2);
					end else begin
						t.kind = K_NUMBER; t.len = to16(cur.plen);
						r1 = '0;
						r1.err = E_UNEXP;
						r1.bad = ".";
						r1.line = to16(cur.st_line);
						r1.col = to16(sat_add(cur.st_col, cur.plen));
						r1.off = to16(sat_add(cur.st_pos, cur.plen));
						n = 2'd2;
						s.stopped = 1'b1;
					end
				end
				M_EXP, M_EXPSIGN: begin
					if ((c == "+" || c == "-") && cur.mode == M_EXP) begin
						s.mode = M_EXPSIGN;
						s.plen = sat_inc(cur.plen, 2'd1);
					end else if (dig(c)) begin
						s.mode = M_EXPDIG;
						s.plen = sat_inc(cur.plen, 2'd1);
					end else begin
						s.stopped = 1'b1; t.err = E_UNEXP; t.bad = b; n = 2'd1;
					end
				end
				M_STR: begin
					if (c == "\"") begin
						s.mode = M_IDLE; t.kind = K_STRING;
						t.off = to16(sat_inc(cur.st_pos, 2'd1));
						t.len = to16(cur.plen); n = 2'd1;
					end else if (c == 8'h0) begin
						s.stopped = 1'b1; t.err = E_UNTERM; t.bad = b; n = 2'd1;
					end else begin
						s.plen = sat_inc(cur.plen, 2'd1);
					end
				end
				M_NAME: begin
					if (wrd(c)) begin
						pl3 = (cur.plen > POS_BITS'(7)) ? 3'd7 : cur.plen[2:0];
						for (int k = 0; k < 4; k++)
							if (cur.kw[k] && ({1'b0, pl3} >= {1'b0, kw_len(2'(k))}
									|| kw_char(2'(k), pl3) != c))
								s.kw[k] = 1'b0;
						s.plen = sat_inc(cur.plen, 2'd1);
					end else begin
						for (int k = 0; k < 4; k++)
							if (cur.kw[k] && cur.plen == POS_BITS'(kw_len(2'(k))))
								kind = K_FALSE + 6'(k);
						t.kind = kind; t.len = to16(cur.plen); n = 2'd1; again = 1'b1;
					end
				end
				default: again = 1'b1;
			endcase
			if (n != 2'd2) r0 = t; else r0 = t;
			if (again && !s.stopped) begin
				tok_t u;
				logic emit_u;
				u = '0;
				emit_u = 1'b0;
				u.line = to16(cur.cur_line);
				u.col = to16(cur.cur_col);
				u.off = to16(cur.pos);
				u.len = 16'd1;
				s.mode = M_IDLE;
				case (c)
					8'h00: begin s.stopped = 1'b1; u.kind = K_EOF; emit_u = 1'b1; end
					",": begin u.kind = 6'd1; emit_u = 1'b1; end
					":": begin u.kind = 6'd2; emit_u = 1'b1; end
					";": begin u.kind = 6'd3; emit_u = 1'b1; end
					"?": begin u.kind = 6'd4; emit_u = 1'b1; end
					"(": begin u.kind = 6'd5; emit_u = 1'b1; end
					")": begin u.kind = 6'd6; emit_u = 1'b1; end
					"[": begin u.kind = 6'd7; emit_u = 1'b1; end
					"]": begin u.kind = 6'd8; emit_u = 1'b1; end
					"-": begin u.kind = K_MINUS; emit_u = 1'b1; end
					"*": begin u.kind = K_STAR; emit_u = 1'b1; end
					"/": begin u.kind = K_SLASH; emit_u = 1'b1; end
					"%": begin u.kind = K_PERCENT; emit_u = 1'b1; end
					default: begin
						if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
						end else begin
							s.st_line = cur.cur_line;
							s.st_col = cur.cur_col;
							s.st_pos = cur.pos;
							s.first = c;
							s.plen = POS_BITS'(1);
							case (c)
								"=": s.mode = M_EQ;
								"|": s.mode = M_PIPE;
								"&": s.mode = M_AMP;
								"!": s.mode = M_BANG;
								"<": s.mode = M_LT;
								">": s.mode = M_GT;
								"+": s.mode = M_PLUS;
								"0": s.mode = M_ZERO;
								"\"": begin s.mode = M_STR; s.plen = '0; end
								default: begin
									if (dig(c)) s.mode = M_INT;
									else if (alp(c) || c == "_") begin
										s.mode = M_NAME;
										s.kw = 4'hf;
										for (int k = 0; k < 4; k++)
											if (kw_char(2'(k), 3'd0) != c) s.kw[k] = 1'b0;
									end else begin
										s.stopped = 1'b1;
										u.kind = K_EOF;
										u.err = E_UNEXP;
										u.bad = (c < 8'h20 || c > 8'h7e) ? "?" : c;
										u.len = 16'd0;
										emit_u = 1'b1;
									end
								end
							endcase
						end
					end
				endcase
				if (emit_u) begin
					if (n == 2'd0) begin r0 = u; n = 2'd1; end
					else begin r1 = u; n = 2'd2; end
				end
			end
			s.pos = sat_inc(cur.pos, 2'd1);
			if (c == 8'h0a) begin
				s.cur_line = sat_inc(cur.cur_line, 2'd1);
				s.cur_col = POS_BITS'(1);
			end else begin
				s.cur_col = sat_inc(cur.cur_col, 2'd1);
			end
		end
		nxt = s;
	end
endmodule
